[hw/rtl/ens_pkg.sv]
// Shared types and constants for the encoder speed and position block.
// No dependencies; compiled first.
package ens_pkg;

   localparam int HW_W       = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int PPR_W      = 16;
   localparam int GEAR_W     = 20;
   localparam int PERIOD_W   = 16;
   localparam int EDGE_SHIFT = 2;
   localparam int DIV_W      = PPR_W + PERIOD_W + GEAR_W + EDGE_SHIFT;
   localparam int Q_W        = HW_W + 1;

   localparam logic [63:0] SPEED_NUM = 64'd60000000;

   localparam logic [PPR_W-1:0]    PPR_RESET    = 16'd1;
   localparam logic [GEAR_W-1:0]   GEAR_RESET   = 20'd1000;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;

   localparam logic [HW_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [HW_W-1:0] SAT_NEG = 32'h8000_0000;

   typedef enum logic [1:0] {
      OP_OVERFLOW   = 2'd0,
      OP_TICK       = 2'd1,
      OP_READ_REVS  = 2'd2,
      OP_READ_SPEED = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PULSES_PER_REV = 2'd0,
      CSR_GEAR_RATIO     = 2'd1,
      CSR_PERIOD_MS      = 2'd2
   } csr_idx_type;

   localparam logic KIND_REVS  = 1'b0;
   localparam logic KIND_SPEED = 1'b1;

   typedef struct packed {
      logic [PPR_W-1:0]    ppr;
      logic [GEAR_W-1:0]   gear;
      logic [PERIOD_W-1:0] period;
   } cfg_type;

   typedef struct packed {
      logic             start;
      logic             neg;
      logic [DIV_W-1:0] divisor;
   } div_ctl_type;

   typedef struct packed {
      logic            done;
      logic [HW_W-1:0] value;
   } div_sts_type;

endpackage

[hw/rtl/ens_if.sv]
// Valid/ready channel interfaces: request, response and register write.
// Depends on ens_pkg.
interface ens_req_if;
   import ens_pkg::*;
   logic                   valid;
   logic                   ready;
   op_type                 op;
   logic signed [HW_W-1:0] hw_count;
   modport source(output valid, op, hw_count, input ready);
   modport sink(input valid, op, hw_count, output ready);
endinterface

interface ens_rsp_if;
   import ens_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   kind;
   logic signed [HW_W-1:0] result_value;
   modport source(output valid, kind, result_value, input ready);
   modport sink(input valid, kind, result_value, output ready);
endinterface

interface ens_csr_if;
   import ens_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

[hw/rtl/ens_regs.sv]
// Configuration registers; zero values read back as one.
// Depends on ens_pkg and ens_csr_if.
module ens_regs (
   input  logic             clock,
   input  logic             reset,
   ens_csr_if.sink          csr_chan,
   output ens_pkg::cfg_type cfg
);
   import ens_pkg::*;

   logic [PPR_W-1:0]    ppr_ff;
   logic [GEAR_W-1:0]   gear_ff;
   logic [PERIOD_W-1:0] period_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ppr_ff    <= PPR_RESET;
         gear_ff   <= GEAR_RESET;
         period_ff <= PERIOD_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_PULSES_PER_REV: ppr_ff    <= csr_chan.data[PPR_W-1:0];
            CSR_GEAR_RATIO:     gear_ff   <= csr_chan.data[GEAR_W-1:0];
            CSR_PERIOD_MS:      period_ff <= csr_chan.data[PERIOD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.ppr    = (ppr_ff == '0) ? PPR_W'(1) : ppr_ff;
   assign cfg.gear   = (gear_ff == '0) ? GEAR_W'(1) : gear_ff;
   assign cfg.period = (period_ff == '0) ? PERIOD_W'(1) : period_ff;

endmodule

[hw/rtl/ens_div.sv]
// Restoring divider, one quotient bit per cycle, signed saturation to 32 bits.
// Depends on ens_pkg.
module ens_div #(
   parameter int DVD_W = 68
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ens_pkg::div_ctl_type ctl,
   input  logic [DVD_W-1:0]     dividend,
   output ens_pkg::div_sts_type sts
);
   import ens_pkg::*;

   localparam int CNT_W = $clog2(DVD_W);

   typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_FIN} dv_state_type;

   dv_state_type     state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DVD_W-1:0] dvd_ff;
   logic [DIV_W-1:0] rem_ff;
   logic [DIV_W-1:0] div_ff;
   logic [Q_W-1:0]   q_ff;
   logic             ovf_ff;
   logic             neg_ff;
   logic             done_ff;
   logic [HW_W-1:0]  value_ff;

   logic [DIV_W:0]   shifted;
   logic             ge;
   logic [DIV_W:0]   diff;
   logic [DIV_W-1:0] rem_in;
   logic [HW_W-1:0]  value_in;

   assign shifted = {rem_ff, dvd_ff[DVD_W-1]};
   assign ge      = shifted >= {1'b0, div_ff};
   assign diff    = shifted - {1'b0, div_ff};
   assign rem_in  = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];

   always_comb begin
      if (!neg_ff) begin
         value_in = (ovf_ff || q_ff > Q_W'(SAT_POS)) ? SAT_POS : q_ff[HW_W-1:0];
      end else begin
         value_in = (ovf_ff || q_ff > Q_W'(SAT_NEG)) ? SAT_NEG
                                                    : HW_W'(0) - q_ff[HW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            DV_IDLE: begin
               if (ctl.start) begin
                  dvd_ff   <= dividend;
                  div_ff   <= ctl.divisor;
                  neg_ff   <= ctl.neg;
                  rem_ff   <= '0;
                  q_ff     <= '0;
                  ovf_ff   <= 1'b0;
                  cnt_ff   <= '0;
                  state_ff <= DV_RUN;
               end
            end
            DV_RUN: begin
               dvd_ff <= {dvd_ff[DVD_W-2:0], 1'b0};
               rem_ff <= rem_in;
               q_ff   <= {q_ff[Q_W-2:0], ge};
               ovf_ff <= ovf_ff | q_ff[Q_W-1];
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(DVD_W - 1)) begin
                  state_ff <= DV_FIN;
               end
            end
            DV_FIN: begin
               value_ff <= value_in;
               done_ff  <= 1'b1;
               state_ff <= DV_IDLE;
            end
            default: state_ff <= DV_IDLE;
         endcase
      end
   end

   assign sts.done  = done_ff;
   assign sts.value = value_ff;

`ifndef NO_ASSERTIONS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> state_ff == DV_IDLE)
      else $error("divider started while busy");
   a_done_after_fin: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(state_ff == DV_FIN))
      else $error("divider done without final step");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held for more than one cycle");
`endif

endmodule

[hw/rtl/encoder_speed_and_position.sv]
// Quadrature x4 encoder speed and position block, top level.
// Depends on ens_pkg, ens_if, ens_regs and ens_div.
//
// Request words carry an op and the external edge counter value. Overflow
// fold returns nothing. Read speed returns the stored speed (kind 1) through
// the result register and the wait state. Tick and read revolutions run
// through one shared 32x32 multiplier (divisor product, then the two halves
// of the scaled dividend) and then through a restoring divider that retires
// one quotient bit per cycle over 32 plus the bit width of the larger scale
// constant (68 bits with default parameters). Tick stores the new speed and
// returns nothing; read revolutions returns milli-revolutions (kind 0).
// req_chan.ready is low while a word is in work. A finished response sits in
// an output register; a stalled receiver holds it there, and the next word
// is still taken, but its own response waits until that register frees.
// Register writes go through csr_chan and are always ready; the user must
// make them only while the block is idle, and the block itself does not
// enforce it. Reset clears all position and speed state and loads the
// register defaults; no clearing pass is needed.
module encoder_speed_and_position #(
   parameter int UNIT_SCALE_FACTOR = 1000,
   parameter int GEAR_SCALE        = 1000
) (
   input logic       clock,
   input logic       reset,
   ens_req_if.sink   req_chan,
   ens_rsp_if.source rsp_chan,
   ens_csr_if.sink   csr_chan
);
   import ens_pkg::*;

   localparam logic [63:0] SPEED_MUL = SPEED_NUM * 64'(GEAR_SCALE);
   localparam logic [63:0] REV_MUL   = 64'(UNIT_SCALE_FACTOR) * 64'(GEAR_SCALE);
   localparam logic [63:0] MAX_MUL   = (SPEED_MUL > REV_MUL) ? SPEED_MUL : REV_MUL;
   localparam int          MUL_W     = $clog2(MAX_MUL + 64'd1);
   localparam int          DVD_W     = HW_W + MUL_W;
   localparam int          ACC_W     = 96;

   typedef enum logic [3:0] {
      S_IDLE, S_M0, S_M1, S_M2, S_M3, S_M4, S_DIV, S_WAIT
   } state_type;

   cfg_type     cfg;
   div_ctl_type div_ctl;
   div_sts_type div_sts;

   state_type       state_ff;
   logic [HW_W-1:0] ext_ff;
   logic [HW_W-1:0] prev_ff;
   logic [HW_W-1:0] carried_ff;
   logic [HW_W-1:0] speed_ff;
   logic [HW_W-1:0] mag_ff;
   logic            neg_ff;
   logic            is_speed_ff;
   logic [63:0]     prod_ff;
   logic [63:0]     lo_ff;
   logic [DIV_W-1:0] divisor_ff;
   logic            res_kind_ff;
   logic [HW_W-1:0] res_value_ff;
   logic            rsp_valid_ff;
   logic            rsp_kind_ff;
   logic [HW_W-1:0] rsp_value_ff;

   logic [31:0]      mul_a;
   logic [31:0]      mul_b;
   logic [63:0]      prod_in;
   logic [HW_W-1:0]  total_in;
   logic [HW_W-1:0]  delta_in;
   logic [HW_W-1:0]  tot_mag;
   logic [HW_W-1:0]  delta_mag;
   logic [ACC_W-1:0] acc_in;
   logic             req_take;
   logic             rsp_free;
   logic             rsp_load;

   ens_regs u_regs (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   ens_div #(.DVD_W(DVD_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (acc_in[DVD_W-1:0]),
      .sts      (div_sts)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_load       = (state_ff == S_WAIT) && rsp_free;

   assign total_in  = ext_ff + req_chan.hw_count;
   assign delta_in  = total_in - prev_ff + carried_ff;
   assign tot_mag   = total_in[HW_W-1] ? HW_W'(0) - total_in : total_in;
   assign delta_mag = delta_in[HW_W-1] ? HW_W'(0) - delta_in : delta_in;

   always_comb begin
      unique case (state_ff)
         S_M0: begin
            mul_a = 32'(cfg.ppr);
            mul_b = is_speed_ff ? 32'(cfg.period) : 32'd1;
         end
         S_M1: begin
            mul_a = prod_ff[31:0];
            mul_b = 32'(cfg.gear);
         end
         S_M2: begin
            mul_a = mag_ff;
            mul_b = is_speed_ff ? SPEED_MUL[31:0] : REV_MUL[31:0];
         end
         S_M3: begin
            mul_a = mag_ff;
            mul_b = is_speed_ff ? SPEED_MUL[63:32] : REV_MUL[63:32];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;
   assign acc_in  = {32'd0, lo_ff} + {prod_ff, 32'd0};

   assign div_ctl.start   = (state_ff == S_M4);
   assign div_ctl.neg     = neg_ff;
   assign div_ctl.divisor = divisor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ext_ff       <= '0;
         prev_ff      <= '0;
         carried_ff   <= '0;
         speed_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  unique case (req_chan.op)
                     OP_OVERFLOW: begin
                        ext_ff <= total_in;
                     end
                     OP_TICK: begin
                        carried_ff  <= '0;
                        prev_ff     <= total_in;
                        neg_ff      <= delta_in[HW_W-1];
                        mag_ff      <= delta_mag;
                        is_speed_ff <= 1'b1;
                        state_ff    <= S_M0;
                     end
                     OP_READ_REVS: begin
                        carried_ff  <= carried_ff + total_in - prev_ff;
                        ext_ff      <= '0;
                        prev_ff     <= '0;
                        neg_ff      <= total_in[HW_W-1];
                        mag_ff      <= tot_mag >> EDGE_SHIFT;
                        is_speed_ff <= 1'b0;
                        state_ff    <= S_M0;
                     end
                     OP_READ_SPEED: begin
                        res_kind_ff  <= KIND_SPEED;
                        res_value_ff <= speed_ff;
                        state_ff     <= S_WAIT;
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_M0: begin
               prod_ff  <= prod_in;
               state_ff <= S_M1;
            end
            S_M1: begin
               prod_ff  <= prod_in;
               state_ff <= S_M2;
            end
            S_M2: begin
               divisor_ff <= is_speed_ff ? {prod_ff[DIV_W-EDGE_SHIFT-1:0], 2'b00}
                                         : prod_ff[DIV_W-1:0];
               prod_ff    <= prod_in;
               state_ff   <= S_M3;
            end
            S_M3: begin
               lo_ff    <= prod_ff;
               prod_ff  <= prod_in;
               state_ff <= S_M4;
            end
            S_M4: begin
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_sts.done) begin
                  if (is_speed_ff) begin
                     speed_ff <= div_sts.value;
                     state_ff <= S_IDLE;
                  end else begin
                     res_kind_ff  <= KIND_REVS;
                     res_value_ff <= div_sts.value;
                     state_ff     <= S_WAIT;
                  end
               end
            end
            S_WAIT: begin
               if (rsp_load) begin
                  rsp_kind_ff  <= res_kind_ff;
                  rsp_value_ff <= res_value_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.kind         = rsp_kind_ff;
   assign rsp_chan.result_value = rsp_value_ff;

`ifndef NO_ASSERTIONS
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> state_ff == S_DIV)
      else $error("divider result outside divide step");
   a_long_ops_start: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_chan.op == OP_TICK || req_chan.op == OP_READ_REVS)
      |=> state_ff == S_M0)
      else $error("tick or revolution read did not start sequence");
   a_load_from_wait: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_WAIT))
      else $error("response loaded outside wait step");
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_ctl.start |-> div_ctl.divisor != '0)
      else $error("zero divisor");
`endif

endmodule
